// ===== rtl/pse_pkg.sv =====
// shared types and constants of the polyline stroke expander
// no dependencies
package pse_pkg;

	typedef struct packed {
		logic [15:0] stroke_width;
		logic [15:0] viewport_width;
		logic [15:0] viewport_height;
		logic        close_contour;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_STROKE_WIDTH    = 2'd0,
		REG_VIEWPORT_WIDTH  = 2'd1,
		REG_VIEWPORT_HEIGHT = 2'd2,
		REG_CLOSE_CONTOUR   = 2'd3
	} reg_idx_t;

	localparam logic [15:0] STROKE_WIDTH_RST    = 16'd256;
	localparam logic [15:0] VIEWPORT_WIDTH_RST  = 16'd1920;
	localparam logic [15:0] VIEWPORT_HEIGHT_RST = 16'd1080;
	localparam logic [15:0] DEFAULT_STROKE      = 16'd256;

	localparam int SQ_W      = 64;
	localparam int LEN_W     = 32;
	localparam int DIV_W     = 56;
	localparam int DIV_CNT_W = 6;
	localparam int OFF_W     = 26;
	localparam int CMD_DEPTH = 4;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [LEN_W-1:0]     divisor;
		logic [DIV_CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/polyline_stroke_expander_top.sv =====
// Polyline stroke expander. Input channel: push/full with point_x, point_y,
// path_end; a transfer happens when push is high and full is low. Result
// channel: empty/pop; the oldest triangle stays on the vert_* ports and
// last_triangle while empty is low and moves on a transfer with pop high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high; write only while the block is idle.
// A front stage tracks the path and queues up to four segment commands; a
// back stage expands one segment at a time into two triangles. A segment runs
// a 32-step square root, then ten divisions on one shared one-bit-per-cycle
// divider (two of 56 steps for the normal offset, eight of max(COORD_BITS+13,36)
// steps for device mapping), each set up in the COR, NUM, ABS and GO states.
// A point that closes a contour costs two segments. Points that make no
// segment write no command to the queue.
// Reset clears the path state, both queues and loads the default registers.
// A stalled receiver holds two triangles in the back stage; the front keeps
// taking points until the command queue fills, then raises full.
// Depends on pse_pkg, pse_front, pse_queue, pse_back, pse_div.
module polyline_stroke_expander_top #(
	parameter int COORD_BITS = 24,
	parameter int NDC_BITS   = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         path_end,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [NDC_BITS-1:0]   vert_a_x,
	output logic signed [NDC_BITS-1:0]   vert_a_y,
	output logic signed [NDC_BITS-1:0]   vert_b_x,
	output logic signed [NDC_BITS-1:0]   vert_b_y,
	output logic signed [NDC_BITS-1:0]   vert_c_x,
	output logic signed [NDC_BITS-1:0]   vert_c_y,
	output logic                         last_triangle,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_data
);
	localparam int CMD_W = 4 * COORD_BITS + 1;

	pse_pkg::cfg_t    cfg_q;
	logic             q_wr;
	logic [CMD_W-1:0] q_wdata;
	logic             q_full;
	logic             q_empty;
	logic [CMD_W-1:0] q_rdata;
	logic             q_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stroke_width    <= pse_pkg::STROKE_WIDTH_RST;
			cfg_q.viewport_width  <= pse_pkg::VIEWPORT_WIDTH_RST;
			cfg_q.viewport_height <= pse_pkg::VIEWPORT_HEIGHT_RST;
			cfg_q.close_contour   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pse_pkg::reg_idx_t'(cfg_index))
				pse_pkg::REG_STROKE_WIDTH:    cfg_q.stroke_width    <= cfg_data;
				pse_pkg::REG_VIEWPORT_WIDTH:  cfg_q.viewport_width  <= cfg_data;
				pse_pkg::REG_VIEWPORT_HEIGHT: cfg_q.viewport_height <= cfg_data;
				pse_pkg::REG_CLOSE_CONTOUR:   cfg_q.close_contour   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pse_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.point_x       (point_x),
		.point_y       (point_y),
		.path_end      (path_end),
		.full          (full),
		.close_contour (cfg_q.close_contour),
		.q_full        (q_full),
		.q_wr          (q_wr),
		.q_data        (q_wdata)
	);

	pse_queue #(
		.WIDTH (CMD_W),
		.DEPTH (pse_pkg::CMD_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	pse_back #(
		.COORD_BITS (COORD_BITS),
		.NDC_BITS   (NDC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd_valid     (!q_empty),
		.cmd_data      (q_rdata),
		.cmd_pop       (q_rd),
		.empty         (empty),
		.pop           (pop),
		.vert_a_x      (vert_a_x),
		.vert_a_y      (vert_a_y),
		.vert_b_x      (vert_b_x),
		.vert_b_y      (vert_b_y),
		.vert_c_x      (vert_c_x),
		.vert_c_y      (vert_c_y),
		.last_triangle (last_triangle)
	);

endmodule

// ===== rtl/pse_queue.sv =====
// small register queue carrying segment commands from front to back
// no dependencies
module pse_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_rd |=> cnt_q == CW'(DEPTH))
		else $error("queue count moved past depth");
	a_count_write: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue count missed a write");
	a_count_read: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("queue count missed a read");
`endif

endmodule

// ===== rtl/pse_front.sv =====
// front end: takes path points, tracks path state, emits segment commands
// depends on pse_pkg
module pse_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         path_end,
	output logic                         full,
	input  logic                         close_contour,
	input  logic                         q_full,
	output logic                         q_wr,
	output logic [4*COORD_BITS:0]        q_data
);
	localparam int CMD_W = 4 * COORD_BITS + 1;

	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;
	logic [1:0]                   seen_q;
	logic                         pend_q;
	logic [CMD_W-1:0]             pend_cmd_q;
	logic                         accept;
	logic                         seg1;
	logic                         seg2;
	logic [CMD_W-1:0]             cmd1;
	logic [CMD_W-1:0]             cmd2;

	assign full   = pend_q || q_full;
	assign accept = push && !full;

	assign seg1 = (seen_q != 2'd0) && ((point_x != prev_x_q) || (point_y != prev_y_q));
	assign seg2 = path_end && close_contour && (seen_q != 2'd0)
		&& ((point_x != start_x_q) || (point_y != start_y_q));

	assign cmd1 = {prev_x_q, prev_y_q, point_x, point_y, !seg2};
	assign cmd2 = {point_x, point_y, start_x_q, start_y_q, 1'b1};

	assign q_wr   = pend_q ? !q_full : (accept && (seg1 || seg2));
	assign q_data = pend_q ? pend_cmd_q : (seg1 ? cmd1 : cmd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				if (path_end) begin
					seen_q <= 2'd0;
				end else if (seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
				pend_q <= seg1 && seg2;
			end else if (pend_q && !q_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q   <= point_x;
			prev_y_q   <= point_y;
			pend_cmd_q <= cmd2;
			if (seen_q == 2'd0) begin
				start_x_q <= point_x;
				start_y_q <= point_y;
			end
		end
	end

`ifndef SYNTHESIS
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && path_end |=> seen_q == 2'd0)
		else $error("path end did not restart the path");
	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !q_full |=> !pend_q)
		else $error("pending closing segment not forwarded");
	a_wr_space: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("command written into a full queue");
`endif

endmodule

// ===== rtl/pse_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on pse_pkg
module pse_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pse_pkg::div_req_t  req,
	output pse_pkg::div_rsp_t  rsp
);
	localparam int DW = pse_pkg::DIV_W;
	localparam int LW = pse_pkg::LEN_W;
	localparam int NW = pse_pkg::DIV_CNT_W;

	logic [LW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [LW-1:0] dvs_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [LW:0]   rsh;
	logic          ge;
	logic [LW:0]   rnext;

	assign rsh   = {rem_q, quo_q[DW-1]};
	assign ge    = rsh >= {1'b0, dvs_q};
	assign rnext = ge ? rsh - {1'b0, dvs_q} : rsh;

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend << (NW'(DW) - req.nbits);
		end else if (busy_q) begin
			rem_q <= rnext[LW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divider stopped without done");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
`endif

endmodule

// ===== rtl/pse_back.sv =====
// back end: expands one segment into two triangles in device coordinates
// depends on pse_pkg and pse_div
module pse_back #(
	parameter int COORD_BITS = 24,
	parameter int NDC_BITS   = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pse_pkg::cfg_t              cfg,
	input  logic                       cmd_valid,
	input  logic [4*COORD_BITS:0]      cmd_data,
	output logic                       cmd_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [NDC_BITS-1:0] vert_a_x,
	output logic signed [NDC_BITS-1:0] vert_a_y,
	output logic signed [NDC_BITS-1:0] vert_b_x,
	output logic signed [NDC_BITS-1:0] vert_b_y,
	output logic signed [NDC_BITS-1:0] vert_c_x,
	output logic signed [NDC_BITS-1:0] vert_c_y,
	output logic                       last_triangle
);
	localparam int CB        = COORD_BITS;
	localparam int NB        = NDC_BITS;
	localparam int DW        = pse_pkg::DIV_W;
	localparam int LW        = pse_pkg::LEN_W;
	localparam int SW        = pse_pkg::SQ_W;
	localparam int OW        = pse_pkg::OFF_W;
	localparam int NW        = pse_pkg::DIV_CNT_W;
	localparam int LEN_SHIFT = (CB < 31) ? 62 - 2 * CB : 0;
	localparam int KSH       = LEN_SHIFT / 2 + 7;
	localparam int D_W       = CB + 1;
	localparam int P_W       = CB + 18;
	localparam int CW        = CB + 11;
	localparam int DEV_N     = (CB + 13 > 36) ? CB + 13 : 36;
	localparam logic [DW-1:0] Q_POS = (DW'(1) << (NB - 1)) - DW'(1);
	localparam logic [DW-1:0] Q_NEG = DW'(1) << (NB - 1);
	localparam logic signed [NB-1:0] POS_MAX = {1'b0, {(NB - 1){1'b1}}};
	localparam logic signed [NB-1:0] NEG_MIN = {1'b1, {(NB - 1){1'b0}}};

	typedef enum logic [3:0] {
		B_IDLE, B_DIFF, B_MUL, B_SUM, B_SQRT, B_COR, B_NUM, B_ABS, B_GO, B_WAIT, B_OUT
	} state_t;

	state_t                  state_q;
	logic signed [CB-1:0]    sx_q, sy_q, ex_q, ey_q;
	logic                    last_q;
	logic signed [D_W-1:0]   dx_q, dy_q;
	logic [2*D_W-1:0]        sqx_q, sqy_q;
	logic signed [P_W-1:0]   pdx_q, pdy_q;
	logic [SW-1:0]           v_q, r_q;
	logic [4:0]              it_q;
	logic [3:0]              op_q;
	logic signed [OW-1:0]    ox_q, oy_q;
	logic signed [CW-1:0]    cor_q;
	logic signed [DW-1:0]    num_q;
	logic [DW-1:0]           mag_q;
	logic                    neg_q;
	logic signed [NB-1:0]    dev_q [8];
	logic signed [NB-1:0]    ov_q [8];
	logic                    olast_q;
	logic [1:0]              ocnt_q;

	pse_pkg::div_req_t       req;
	pse_pkg::div_rsp_t       rsp;
	logic [15:0]             sw_eff, w_eff, h_eff;
	logic [D_W-1:0]          adx, ady;
	logic [SW-1:0]           bitv, trial;
	logic [3:0]              kk;
	logic signed [CB-1:0]    pt;
	logic signed [OW-1:0]    off;
	logic signed [CW-1:0]    cor;
	logic signed [DEV_N-1:0] dv;
	logic signed [DW-1:0]    num;
	logic [LW-1:0]           den;
	logic [DW-1:0]           q;
	logic signed [NB-1:0]    sat;
	logic                    first;

	pse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign sw_eff = (cfg.stroke_width == '0) ? pse_pkg::DEFAULT_STROKE : cfg.stroke_width;
	assign w_eff  = (cfg.viewport_width == '0) ? 16'd1 : cfg.viewport_width;
	assign h_eff  = (cfg.viewport_height == '0) ? 16'd1 : cfg.viewport_height;

	assign adx   = dx_q[D_W-1] ? D_W'(-dx_q) : D_W'(dx_q);
	assign ady   = dy_q[D_W-1] ? D_W'(-dy_q) : D_W'(dy_q);
	assign bitv  = SW'(1) << {it_q, 1'b0};
	assign trial = r_q + bitv;

	assign kk  = op_q - 4'd2;
	assign pt  = kk[0] ? (kk[2] ? ey_q : sy_q) : (kk[2] ? ex_q : sx_q);
	assign off = kk[0] ? oy_q : ox_q;
	assign cor = kk[1] ? (CW'(pt) <<< 8) - CW'(off) : (CW'(pt) <<< 8) + CW'(off);
	assign dv  = kk[0] ? (DEV_N'(h_eff) << 16) - (DEV_N'(cor_q) <<< 1)
	                   : (DEV_N'(cor_q) <<< 1) - (DEV_N'(w_eff) << 16);

	always_comb begin
		case (op_q)
			4'd0:    num = -(DW'(pdy_q) <<< KSH);
			4'd1:    num = DW'(pdx_q) <<< KSH;
			default: num = DW'(dv);
		endcase
	end

	assign den = (op_q < 4'd2) ? r_q[LW-1:0] : LW'(kk[0] ? h_eff : w_eff);

	assign req.start    = (state_q == B_GO);
	assign req.dividend = mag_q + DW'(den >> 1);
	assign req.divisor  = den;
	assign req.nbits    = (op_q < 4'd2) ? NW'(DW) : NW'(DEV_N);

	assign q = rsp.quot;
	always_comb begin
		if (neg_q) begin
			sat = (q > Q_NEG) ? NEG_MIN : NB'(-q);
		end else begin
			sat = (q > Q_POS) ? POS_MAX : NB'(q);
		end
	end

	assign cmd_pop = (state_q == B_IDLE) && cmd_valid;

	assign empty         = (ocnt_q == 2'd0);
	assign first         = (ocnt_q == 2'd2);
	assign vert_a_x      = first ? ov_q[0] : ov_q[4];
	assign vert_a_y      = first ? ov_q[1] : ov_q[5];
	assign vert_b_x      = ov_q[2];
	assign vert_b_y      = ov_q[3];
	assign vert_c_x      = first ? ov_q[4] : ov_q[6];
	assign vert_c_y      = first ? ov_q[5] : ov_q[7];
	assign last_triangle = first ? 1'b0 : olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ocnt_q  <= 2'd0;
			op_q    <= 4'd0;
			it_q    <= 5'd0;
		end else begin
			if (state_q == B_OUT && ocnt_q == 2'd0) begin
				ocnt_q <= 2'd2;
			end else if (pop && ocnt_q != 2'd0) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						sx_q    <= cmd_data[4*CB:3*CB+1];
						sy_q    <= cmd_data[3*CB:2*CB+1];
						ex_q    <= cmd_data[2*CB:CB+1];
						ey_q    <= cmd_data[CB:1];
						last_q  <= cmd_data[0];
						state_q <= B_DIFF;
					end
				end
				B_DIFF: begin
					dx_q    <= D_W'(ex_q) - D_W'(sx_q);
					dy_q    <= D_W'(ey_q) - D_W'(sy_q);
					state_q <= B_MUL;
				end
				B_MUL: begin
					sqx_q   <= adx * adx;
					sqy_q   <= ady * ady;
					pdx_q   <= dx_q * $signed({1'b0, sw_eff});
					pdy_q   <= dy_q * $signed({1'b0, sw_eff});
					state_q <= B_SUM;
				end
				B_SUM: begin
					v_q     <= SW'({1'b0, sqx_q} + {1'b0, sqy_q}) << LEN_SHIFT;
					r_q     <= '0;
					it_q    <= 5'd31;
					state_q <= B_SQRT;
				end
				B_SQRT: begin
					if (v_q >= trial) begin
						v_q <= v_q - trial;
						r_q <= (r_q >> 1) + bitv;
					end else begin
						r_q <= r_q >> 1;
					end
					it_q <= it_q - 5'd1;
					if (it_q == 5'd0) begin
						op_q    <= 4'd0;
						state_q <= B_COR;
					end
				end
				B_COR: begin
					cor_q   <= cor;
					state_q <= B_NUM;
				end
				B_NUM: begin
					num_q   <= num;
					state_q <= B_ABS;
				end
				B_ABS: begin
					neg_q   <= num_q[DW-1];
					mag_q   <= num_q[DW-1] ? DW'(-num_q) : DW'(num_q);
					state_q <= B_GO;
				end
				B_GO: begin
					state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (rsp.done) begin
						case (op_q)
							4'd0:    ox_q <= neg_q ? OW'(-q) : OW'(q);
							4'd1:    oy_q <= neg_q ? OW'(-q) : OW'(q);
							default: dev_q[kk[2:0]] <= sat;
						endcase
						op_q    <= op_q + 4'd1;
						state_q <= (op_q == 4'd9) ? B_OUT : B_COR;
					end
				end
				B_OUT: begin
					if (ocnt_q == 2'd0) begin
						ov_q    <= dev_q;
						olast_q <= last_q;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result buffer count out of range");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_OUT && ocnt_q == 2'd0 |=> ocnt_q == 2'd2 && state_q == B_IDLE)
		else $error("triangle pair not loaded");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == B_WAIT)
		else $error("divider result arrived outside wait");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == B_DIFF)
		else $error("command transfer did not start a segment");
`endif

endmodule

// ===== tb/sv/polyline_stroke_expander_top_tb.sv =====
// self-checking testbench of polyline_stroke_expander_top: directed table, then random paths
// a triangle predictor feeds a queue that each result transfer is checked against
// depends on pse_pkg and polyline_stroke_expander_top
module polyline_stroke_expander_top_tb;

	localparam int CW      = 24;
	localparam int NW      = 20;
	localparam int DRAIN   = 1500;
	localparam int HOLDOFF = 4000;

	typedef struct packed {
		logic signed [NW-1:0] ax;
		logic signed [NW-1:0] ay;
		logic signed [NW-1:0] bx;
		logic signed [NW-1:0] by;
		logic signed [NW-1:0] cx;
		logic signed [NW-1:0] cy;
		logic                 last_tri;
	} tri_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		bit                   pe;
		int                   n_tris;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic path_end = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [NW-1:0] vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y;
	logic last_triangle;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	tri_t pending_tris[$];
	int errors = 0;
	bit hold_off_req = 1'b0;
	bit steady_pop = 1'b0;

	longint unsigned m_stroke, m_vw, m_vh;
	bit m_close;
	longint m_prev_x, m_prev_y, m_start_x, m_start_y;
	int m_seen;

	polyline_stroke_expander_top #(.COORD_BITS(CW), .NDC_BITS(NW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.point_x(point_x), .point_y(point_y), .path_end(path_end),
		.empty(empty), .pop(pop),
		.vert_a_x(vert_a_x), .vert_a_y(vert_a_y),
		.vert_b_x(vert_b_x), .vert_b_y(vert_b_y),
		.vert_c_x(vert_c_x), .vert_c_y(vert_c_y),
		.last_triangle(last_triangle),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint div_round(longint num, longint unsigned den);
		longint unsigned mag, q;
		mag = num < 0 ? longint'(-num) : longint'(num);
		q = (mag + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [NW-1:0] sat_ndc(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (NW - 1)) - 1;
		lo = -(longint'(1) <<< (NW - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[NW-1:0];
	endfunction

	function automatic logic signed [NW-1:0] ndc_x(longint x);
		longint unsigned w;
		w = m_vw != 0 ? m_vw : 1;
		return sat_ndc(div_round(2 * x - longint'(65536 * w), w));
	endfunction

	function automatic logic signed [NW-1:0] ndc_y(longint y);
		longint unsigned h;
		h = m_vh != 0 ? m_vh : 1;
		return sat_ndc(div_round(longint'(65536 * h) - 2 * y, h));
	endfunction

	function automatic tri_t make_tri(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		tri_t t;
		t.ax = ndc_x(ax); t.ay = ndc_y(ay);
		t.bx = ndc_x(bx); t.by = ndc_y(by);
		t.cx = ndc_x(cx); t.cy = ndc_y(cy);
		t.last_tri = 1'b0;
		return t;
	endfunction

	task automatic expand_segment(longint sx, longint sy, longint ex, longint ey,
			ref tri_t tris[$]);
		longint dx, dy, ox, oy, s0x, s0y, e0x, e0y;
		longint unsigned adx, ady, len_q, sw;
		dx = ex - sx;
		dy = ey - sy;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx * adx + ady * ady == 0) return;
		len_q = int_sqrt((adx * adx + ady * ady) << (62 - 2 * CW));
		if (len_q == 0) return;
		sw = m_stroke != 0 ? m_stroke : 64'(pse_pkg::DEFAULT_STROKE);
		ox = div_round(-dy * longint'(sw) * (longint'(1) <<< ((62 - 2 * CW) / 2 + 7)), len_q);
		oy = div_round(dx * longint'(sw) * (longint'(1) <<< ((62 - 2 * CW) / 2 + 7)), len_q);
		s0x = sx * 256; s0y = sy * 256; e0x = ex * 256; e0y = ey * 256;
		tris.insert(tris.size(),
			make_tri(s0x + ox, s0y + oy, s0x - ox, s0y - oy, e0x + ox, e0y + oy));
		tris.insert(tris.size(),
			make_tri(e0x + ox, e0y + oy, s0x - ox, s0y - oy, e0x - ox, e0y - oy));
	endtask

	task automatic predict_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, bit pe,
			output int n);
		tri_t tris[$];
		longint px, py;
		px = longint'(x);
		py = longint'(y);
		if (m_seen == 0) begin
			m_start_x = px;
			m_start_y = py;
		end else begin
			expand_segment(m_prev_x, m_prev_y, px, py, tris);
		end
		m_prev_x = px;
		m_prev_y = py;
		if (m_seen < 2) m_seen++;
		if (pe) begin
			if (m_close && m_seen >= 2) expand_segment(px, py, m_start_x, m_start_y, tris);
			m_seen = 0;
		end
		n = tris.size();
		if (n > 0) tris[n-1].last_tri = 1'b1;
		foreach (tris[i]) pending_tris.insert(pending_tris.size(), tris[i]);
	endtask

	task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, bit pe,
			int want_n);
		int n;
		point_x = x;
		point_y = y;
		path_end = pe;
		push = 1'b1;
		do @(posedge clk); while (full);
		predict_point(x, y, pe, n);
		if (want_n >= 0 && n != want_n) begin
			$display("%0t: triangle count expected %0d actual %0d", $time, want_n, n);
			errors++;
		end
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic drain_block();
		while (pending_tris.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(pse_pkg::reg_idx_t idx, logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pse_pkg::REG_STROKE_WIDTH:    m_stroke = 64'(val);
			pse_pkg::REG_VIEWPORT_WIDTH:  m_vw = 64'(val);
			pse_pkg::REG_VIEWPORT_HEIGHT: m_vh = 64'(val);
			pse_pkg::REG_CLOSE_CONTOUR:   m_close = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(logic [15:0] sw, logic [15:0] w, logic [15:0] h, bit cl);
		drain_block();
		write_reg(pse_pkg::REG_STROKE_WIDTH, sw);
		write_reg(pse_pkg::REG_VIEWPORT_WIDTH, w);
		write_reg(pse_pkg::REG_VIEWPORT_HEIGHT, h);
		write_reg(pse_pkg::REG_CLOSE_CONTOUR, {15'd0, cl});
	endtask

	function automatic logic signed [CW-1:0] rand_coord(longint unsigned span);
		if ($urandom_range(0, 3) == 0) return CW'($urandom);
		return CW'($urandom_range(0, 32'(span * 256 + 512)));
	endfunction

	task automatic random_paths(int count);
		int sent, len, burst;
		logic signed [CW-1:0] x, y, x0, y0;
		sent = 0;
		burst = $urandom_range(1, 8);
		while (sent < count) begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				if (k > 0 && $urandom_range(0, 9) == 0) begin
					x = x;
				end else if (k == len - 1 && k > 0 && $urandom_range(0, 4) == 0) begin
					x = x0;
					y = y0;
				end else begin
					x = rand_coord(m_vw);
					y = rand_coord(m_vh);
				end
				if (k == 0) begin
					x0 = x;
					y0 = y;
				end
				send_point(x, y, k == len - 1 || $urandom_range(0, 19) == 0, -1);
				sent++;
				if (--burst == 0) begin
					repeat ($urandom_range(1, 40)) @(negedge clk);
					burst = $urandom_range(1, 8);
				end
			end
		end
	endtask

	// receiver: steady or random stall pattern, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				pop = 1'b0;
				repeat (HOLDOFF) @(negedge clk);
				hold_off_req = 1'b0;
			end
			pop = steady_pop ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		tri_t got, want;
		if (pop && !empty) begin
			got = {vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, last_triangle};
			if (pending_tris.size() == 0) begin
				$display("%0t: triangle transfer expected none actual %h", $time, got);
				errors++;
			end else begin
				want = pending_tris.pop_front();
				if (got.ax !== want.ax) begin
					$display("%0t: vert_a_x expected %0d actual %0d", $time, want.ax, got.ax);
					errors++;
				end
				if (got.ay !== want.ay) begin
					$display("%0t: vert_a_y expected %0d actual %0d", $time, want.ay, got.ay);
					errors++;
				end
				if (got.bx !== want.bx) begin
					$display("%0t: vert_b_x expected %0d actual %0d", $time, want.bx, got.bx);
					errors++;
				end
				if (got.by !== want.by) begin
					$display("%0t: vert_b_y expected %0d actual %0d", $time, want.by, got.by);
					errors++;
				end
				if (got.cx !== want.cx) begin
					$display("%0t: vert_c_x expected %0d actual %0d", $time, want.cx, got.cx);
					errors++;
				end
				if (got.cy !== want.cy) begin
					$display("%0t: vert_c_y expected %0d actual %0d", $time, want.cy, got.cy);
					errors++;
				end
				if (got.last_tri !== want.last_tri) begin
					$display("%0t: last_triangle expected %0b actual %0b", $time,
						want.last_tri, got.last_tri);
					errors++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		point_row_t rows_plain[$];
		point_row_t rows_closed[$];
		m_stroke = 64'(pse_pkg::STROKE_WIDTH_RST);
		m_vw = 64'(pse_pkg::VIEWPORT_WIDTH_RST);
		m_vh = 64'(pse_pkg::VIEWPORT_HEIGHT_RST);
		m_close = 1'b0;
		m_prev_x = 0; m_prev_y = 0; m_start_x = 0; m_start_y = 0;
		m_seen = 0;
		rows_plain = '{
			'{24'sd0, 24'sd0, 1'b0, 0},
			'{24'sd0, 24'sd0, 1'b1, 0},
			'{24'sd1280, 24'sd1280, 1'b1, 0},
			'{24'sh7fffff, 24'sh7fffff, 1'b0, 0},
			'{-24'sh800000, -24'sh800000, 1'b1, 2},
			'{24'sd0, 24'sd0, 1'b0, 0},
			'{24'sd256, 24'sd0, 1'b0, 2},
			'{24'sd256, 24'sd256, 1'b1, 2},
			'{24'sd1, 24'sh7fffff, 1'b0, 0},
			'{24'sd0, -24'sh800000, 1'b1, 2}
		};
		rows_closed = '{
			'{24'sd0, 24'sd0, 1'b0, 0},
			'{24'sd2560, 24'sd0, 1'b0, 2},
			'{24'sd0, 24'sd2560, 1'b1, 4},
			'{24'sd0, 24'sd0, 1'b0, 0},
			'{24'sd512, 24'sd0, 1'b0, 2},
			'{24'sd0, 24'sd0, 1'b1, 2},
			'{24'sd700, 24'sd700, 1'b1, 0},
			'{-24'sh800000, 24'sh7fffff, 1'b0, 0},
			'{24'sh7fffff, -24'sh800000, 1'b1, 4}
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		steady_pop = 1'b1;
		foreach (rows_plain[i])
			send_point(rows_plain[i].x, rows_plain[i].y, rows_plain[i].pe, rows_plain[i].n_tris);
		set_config(16'd0, 16'd0, 16'd0, 1'b1);
		foreach (rows_closed[i])
			send_point(rows_closed[i].x, rows_closed[i].y, rows_closed[i].pe,
				rows_closed[i].n_tris);
		steady_pop = 1'b0;
		set_config(16'd65535, 16'd1, 16'd1, 1'b0);
		random_paths(40);
		set_config(16'd256, 16'd64, 16'd48, 1'b1);
		hold_off_req = 1'b1;
		random_paths(50);
		set_config(16'd65535, 16'd65535, 16'd65535, 1'b1);
		random_paths(40);
		for (int p = 0; p < 5; p++) begin
			set_config(16'($urandom), 16'($urandom_range(1, 2000)),
				16'($urandom_range(1, 2000)), 1'($urandom_range(0, 1)));
			steady_pop = (p == 2);
			random_paths(45);
		end
		steady_pop = 1'b0;
		drain_block();
		if (errors == 0 && pending_tris.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
